### rtl/core/ordered_list_insert_delete_dump_unit_defines.svh
// Assertion macros shared by the checker of the ordered list unit.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ORDERED_LIST_INSERT_DELETE_DUMP_UNIT_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DUMP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLID_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered list check failed");

// The consequent must hold in the cycle after the antecedent.
`define OLID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered list check failed");

`endif

### rtl/core/olid_pkg.sv
// Shared types and constants of the ordered list unit.
// Has no dependencies; used by the cell and the top level.
package olid_pkg;

	// Largest supported list and widths that cover it.
	localparam int CAPACITY_MAX = 64;
	localparam int CNT_W        = 7;
	localparam int POS_W        = 6;
	localparam int DATA_W       = 32;

	// Request actions as carried on the input tuser.
	localparam logic [1:0] ACT_FRONT  = 2'd0;
	localparam logic [1:0] ACT_BACK   = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_SHOW   = 2'd3;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_FRONT,
		OP_BACK,
		OP_REMOVE,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [CNT_W-1:0]    count;
		logic [POS_W-1:0]    pos;
		logic [DATA_W-1:0]   value;
	} cell_ctrl_t;

endpackage

### rtl/core/ordered_list_insert_delete_dump_unit.sv
// Top level of the ordered list unit: request decode, cell chain, dump sequencer.
// Depends on olid_pkg and olid_cell.
//
// Usage:
// Requests arrive on the s_ channel: s_tuser carries the action, s_tdata the
// value and the position. Each transfer updates the list, and then the whole
// list is dumped on the m_ channel from front to back, one entry per cycle
// while m_tready allows, with m_tlast on the final entry. An empty list gives
// one transfer with the empty flag set and a zero value.
// Output timing: the request moves the sequencer into its dump state, and the
// output register then loads the first entry from the head of the chain.
// Throughput: a new request is taken only once the dump of the last one has
// ended, and s_tready is high only while no dump is running. The dump rotates
// the chain of cells by one place per cycle while the output is not stalled;
// after N rotations, N the entry count after the update, the list is in order.
// Reset clears the entry count and all handshake state; the stored values
// are not cleared and are never read before they are written.
// When the receiver stalls, the output register holds its transfer and the
// rotation pauses until m_tready returns.
module ordered_list_insert_delete_dump_unit #(
	parameter int CAPACITY = olid_pkg::CAPACITY_MAX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] value, [63:32] position
	input  logic [1:0]  s_tuser,  // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] entry_value
	output logic        m_tlast,  // is_last
	output logic [1:0]  m_tuser   // [0] list_empty, [1] request_ignored
);
	import olid_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [CNT_W-1:0]  idx_q;
	logic              ign_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_data_q;
	logic              m_last_q;
	logic              m_empty_q;
	logic              m_ign_q;

	logic              in_xfer;
	logic              full;
	logic              pos_bad;
	logic              ignored;
	logic              load;
	logic              dump_end;
	cell_ctrl_t        ctrl;
	logic [DATA_W-1:0] cell_q [CAPACITY];

	// Request decode, range checks and the operation for the chain.
	always_comb begin
		in_xfer  = s_tvalid && s_tready;
		full     = (count_q == CNT_W'(CAPACITY));
		pos_bad  = s_tdata[63] || (s_tdata[63:32] >= {{(32-CNT_W){1'b0}}, count_q});
		ignored  = 1'b0;
		count_d  = count_q;
		ctrl.op    = OP_HOLD;
		ctrl.count = count_q;
		ctrl.pos   = s_tdata[32 +: POS_W];
		ctrl.value = s_tdata[31:0];
		case (s_tuser)
			ACT_FRONT, ACT_BACK: begin
				ignored = full;
				count_d = count_q + CNT_W'(1);
			end
			ACT_REMOVE: begin
				ignored = pos_bad;
				count_d = count_q - CNT_W'(1);
			end
			default: begin
				ignored = 1'b0;
			end
		endcase
		if (ignored) begin
			count_d = count_q;
		end
		if (in_xfer && !ignored) begin
			case (s_tuser)
				ACT_FRONT:  ctrl.op = OP_FRONT;
				ACT_BACK:   ctrl.op = OP_BACK;
				ACT_REMOVE: ctrl.op = OP_REMOVE;
				default:    ctrl.op = OP_HOLD;
			endcase
		end
		load     = (state_q == ST_DUMP) && (!m_tvalid_q || m_tready);
		dump_end = (count_q == '0) || (idx_q + CNT_W'(1) == count_q);
		if (load && count_q != '0) begin
			ctrl.op = OP_ROTATE;
		end
	end

	// Chain of cells, each passing its entry to a neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = cell_q[i];
		end else begin : g_mid_l
			assign left_d = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_q[i];
		end else begin : g_mid_r
			assign right_d = cell_q[i+1];
		end
		olid_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.from_left  (left_d),
			.from_right (right_d),
			.head       (cell_q[0]),
			.data_q     (cell_q[i])
		);
	end

	// Sequencer state, entry count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			ign_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						ign_q   <= ignored;
						count_q <= count_d;
						idx_q   <= '0;
						state_q <= ST_DUMP;
					end
				end
				ST_DUMP: begin
					if (load) begin
						idx_q <= idx_q + CNT_W'(1);
						if (dump_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload register, loaded with the head of the chain, or zero for an empty list.
	always_ff @(posedge clk) begin
		if (load) begin
			m_data_q  <= (count_q == '0) ? '0 : cell_q[0];
			m_last_q  <= dump_end;
			m_empty_q <= (count_q == '0);
			m_ign_q   <= ign_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = {m_ign_q, m_empty_q};

endmodule

### rtl/core/olid_cell.sv
// One storage cell of the ordered list chain.
// Depends on olid_pkg for the control struct and operation codes.
module olid_cell #(
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  olid_pkg::cell_ctrl_t      ctrl,
	input  logic [olid_pkg::DATA_W-1:0] from_left,
	input  logic [olid_pkg::DATA_W-1:0] from_right,
	input  logic [olid_pkg::DATA_W-1:0] head,
	output logic [olid_pkg::DATA_W-1:0] data_q
);
	import olid_pkg::*;

	logic [CNT_W-1:0] my_idx;
	logic [DATA_W-1:0] data_d;

	assign my_idx = CNT_W'(IDX);

	// Pick the next content of this cell from the broadcast operation.
	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			OP_FRONT: begin
				data_d = (IDX == 0) ? ctrl.value : from_left;
			end
			OP_BACK: begin
				if (my_idx == ctrl.count) begin
					data_d = ctrl.value;
				end
			end
			OP_REMOVE: begin
				if (my_idx >= {1'b0, ctrl.pos}) begin
					data_d = from_right;
				end
			end
			OP_ROTATE: begin
				data_d = (my_idx == ctrl.count - CNT_W'(1)) ? head : from_right;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	// Entries are undefined until written, so the cell has no reset.
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

### rtl/core/olid_checker.sv
// Port-level checker of the ordered list unit and its bind statement.
// Depends on ordered_list_insert_delete_dump_unit_defines.svh.
`include "ordered_list_insert_delete_dump_unit_defines.svh"

module olid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser
);

	// A stalled result keeps its valid and its data.
	`OLID_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// One request at a time: a request transfer closes the input until its dump ends.
	`OLID_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)

	// An empty list is reported by a single, final transfer.
	`OLID_ASSERT_SAME(a_empty_last, m_tvalid && m_tuser[0], m_tlast)

	// The input opens again only after the final result has been loaded.
	`OLID_ASSERT_SAME(a_ready_after_last, $rose(s_tready), m_tvalid && m_tlast)

endmodule

bind ordered_list_insert_delete_dump_unit olid_checker u_olid_checker (.*);
